@@ hdl/mep_pkg.sv @@
package mep_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 28;
  localparam int unsigned IterBitsDef  = 16;

  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned CfgIdxBits   = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_X_MIN    = 3'd0,
    REG_Y_MAX    = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4,
    REG_BAILOUT  = 3'd5,
    REG_COLORS   = 3'd6
  } cfg_reg_e;

  localparam logic signed [31:0] XMinRst    = -32'sd536870912;
  localparam logic signed [31:0] YMaxRst    = 32'sd268435456;
  localparam logic [30:0]        XStepRst   = 31'd3145728;
  localparam logic [30:0]        YStepRst   = 31'd2097152;
  localparam logic [15:0]        MaxIterRst = 16'd100;
  localparam logic [1:0]         BailoutRst = 2'd2;
  localparam logic [4:0]         ColorsRst  = 5'd5;

  // Limits for the iteration loop, already forced into their legal ranges.
  typedef struct packed {
    logic [15:0] lim;
    logic [2:0]  bail_sq;
    logic [4:0]  colors;
  } cfg_t;

endpackage

@@ hdl/mep_if.sv @@
interface mep_pix_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] col;

  modport source (output valid, output row, output col, input ready);
  modport sink   (input valid, input row, input col, output ready);
endinterface

interface mep_res_if #(
  parameter int unsigned ITER_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [3:0]           color_index;
  logic [ITER_BITS-1:0] iteration_index;

  modport source (output valid, output color_index, output iteration_index, input ready);
  modport sink   (input valid, input color_index, input iteration_index, output ready);
endinterface

@@ hdl/mep_front.sv @@
module mep_front import mep_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [31:0]         x_min_i,
  input  logic signed [31:0]         y_max_i,
  input  logic [30:0]                x_step_i,
  input  logic [30:0]                y_step_i,
  mep_pix_if.sink                    pix_i,
  input  logic                       q_ready_i,
  output logic                       q_valid_o,
  output logic [2*(FRAC_BITS+6)-1:0] q_data_o
);

  localparam int unsigned W  = FRAC_BITS + 6;
  localparam int unsigned PW = COORD_BITS + 33;
  localparam int unsigned SW = (PW > FRAC_BITS + 7) ? PW : FRAC_BITS + 7;
  localparam logic signed [SW-1:0] CLim = SW'(4) << FRAC_BITS;

  logic                  stg_valid_q;
  logic [COORD_BITS-1:0] row_q;
  logic [COORD_BITS-1:0] col_q;
  logic signed [SW-1:0]  re_raw;
  logic signed [SW-1:0]  im_raw;
  logic signed [SW-1:0]  re_sat;
  logic signed [SW-1:0]  im_sat;
  logic                  take;

  assign take        = pix_i.valid && pix_i.ready;
  assign pix_i.ready = !stg_valid_q || q_ready_i;

  always_comb begin
    re_raw = SW'(x_min_i) + $signed(SW'(col_q) * SW'(x_step_i));
    im_raw = SW'(y_max_i) - $signed(SW'(row_q) * SW'(y_step_i));
    re_sat = (re_raw > CLim) ? CLim : ((re_raw < -CLim) ? -CLim : re_raw);
    im_sat = (im_raw > CLim) ? CLim : ((im_raw < -CLim) ? -CLim : im_raw);
  end

  assign q_valid_o = stg_valid_q;
  assign q_data_o  = {W'(re_sat), W'(im_sat)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
    end else begin
      if (take) begin
        stg_valid_q <= 1'b1;
        row_q       <= pix_i.row;
        col_q       <= pix_i.col;
      end else if (q_ready_i) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/mep_queue.sv @@
module mep_queue import mep_pkg::*; #(
  parameter int unsigned WIDTH = 2 * (FracBitsDef + 6)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q;
  logic             rd_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= 1'b0;
      rd_q      <= 1'b0;
      cnt_q     <= 2'd0;
      slot_q[0] <= '0;
      slot_q[1] <= '0;
    end else begin
      if (push) begin
        slot_q[wr_q] <= push_data_i;
        wr_q         <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ hdl/mep_back.sv @@
module mep_back import mep_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned ITER_BITS = IterBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cfg_t                       cfg_i,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  logic [2*(FRAC_BITS+6)-1:0] q_data_i,
  mep_res_if.source                  res_o
);

  localparam int unsigned W  = FRAC_BITS + 6;
  localparam int unsigned PW = W + 2;
  localparam int unsigned MW = W + 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQ,
    ST_EVAL
  } state_e;

  state_e                state_q;
  logic signed [W-1:0]   zr_q, zi_q, cr_q, ci_q;
  logic signed [PW-1:0]  sr_q, si_q, cx_q;
  logic [15:0]           it_q;
  logic [3:0]            color_q;
  logic                  out_valid_q;
  logic [3:0]            out_color_q;
  logic [ITER_BITS-1:0]  out_it_q;

  logic signed [2*W-1:0] p_rr, p_ii, p_ri;
  logic signed [MW-1:0]  mag, thr;
  logic                  stop;
  logic                  slot_free;
  logic signed [W-1:0]   zr_next, zi_next;
  logic [3:0]            color_next;

  always_comb begin
    p_rr       = zr_q * zr_q;
    p_ii       = zi_q * zi_q;
    p_ri       = zr_q * zi_q;
    mag        = MW'(sr_q) + MW'(si_q);
    thr        = MW'(cfg_i.bail_sq) << FRAC_BITS;
    stop       = (mag > thr) || (it_q == cfg_i.lim - 16'd1);
    zr_next    = W'(sr_q - si_q + PW'(cr_q));
    zi_next    = W'((cx_q <<< 1) + PW'(ci_q));
    color_next = (5'(color_q) + 5'd1 == cfg_i.colors) ? 4'd0 : color_q + 4'd1;
  end

  assign slot_free             = !out_valid_q || res_o.ready;
  assign q_ready_o             = state_q == ST_IDLE;
  assign res_o.valid           = out_valid_q;
  assign res_o.color_index     = out_color_q;
  assign res_o.iteration_index = out_it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      zr_q        <= '0;
      zi_q        <= '0;
      cr_q        <= '0;
      ci_q        <= '0;
      sr_q        <= '0;
      si_q        <= '0;
      cx_q        <= '0;
      it_q        <= '0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
      out_color_q <= '0;
      out_it_q    <= '0;
    end else begin
      if (out_valid_q && res_o.ready && !(state_q == ST_EVAL && stop)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cr_q    <= q_data_i[2*W-1:W];
            ci_q    <= q_data_i[W-1:0];
            zr_q    <= q_data_i[2*W-1:W];
            zi_q    <= q_data_i[W-1:0];
            it_q    <= '0;
            color_q <= '0;
            state_q <= ST_SQ;
          end
        end
        ST_SQ: begin
          sr_q    <= PW'(p_rr >>> FRAC_BITS);
          si_q    <= PW'(p_ii >>> FRAC_BITS);
          cx_q    <= PW'(p_ri >>> FRAC_BITS);
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          if (stop) begin
            if (slot_free) begin
              out_valid_q <= 1'b1;
              out_color_q <= color_q;
              out_it_q    <= ITER_BITS'(it_q);
              state_q     <= ST_IDLE;
            end
          end else begin
            zr_q    <= zr_next;
            zi_q    <= zi_next;
            it_q    <= it_q + 16'd1;
            color_q <= color_next;
            state_q <= ST_SQ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/mandelbrot_escape_time_pixel_core.sv @@
// Escape-time evaluator for one Mandelbrot pixel per word. The front stage maps
// the row and column to a point c with one multiply-add per axis and pushes it
// into a two-entry queue; the back stage runs z = z*z + c on one shared set of
// three multipliers, alternating a squaring state and an evaluation state per
// iteration; a result waiting in the output register lets the next pixel start
// but holds it at its final evaluation until the register is taken.
module mandelbrot_escape_time_pixel_core import mep_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned ITER_BITS  = IterBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  mep_pix_if.sink                pix_i,
  mep_res_if.source              res_o
);

  localparam int unsigned QW = 2 * (FRAC_BITS + 6);

  logic signed [31:0] x_min_q, y_max_q;
  logic [30:0]        x_step_q, y_step_q;
  logic [15:0]        max_iter_q;
  logic [1:0]         bailout_q;
  logic [4:0]         colors_q;
  cfg_t               cfg;

  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  logic [QW-1:0] fq_data, bq_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= XMinRst;
      y_max_q    <= YMaxRst;
      x_step_q   <= XStepRst;
      y_step_q   <= YStepRst;
      max_iter_q <= MaxIterRst;
      bailout_q  <= BailoutRst;
      colors_q   <= ColorsRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_X_MIN:    x_min_q    <= $signed(cfg_data_i);
        REG_Y_MAX:    y_max_q    <= $signed(cfg_data_i);
        REG_X_STEP:   x_step_q   <= cfg_data_i[30:0];
        REG_Y_STEP:   y_step_q   <= cfg_data_i[30:0];
        REG_MAX_ITER: max_iter_q <= cfg_data_i[15:0];
        REG_BAILOUT:  bailout_q  <= cfg_data_i[1:0];
        REG_COLORS:   colors_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.lim     = (max_iter_q == 16'd0) ? 16'd1 : max_iter_q;
    cfg.bail_sq = (bailout_q == 2'd1 || bailout_q == 2'd0) ? 3'd1 : 3'd4;
    cfg.colors  = (colors_q == 5'd0) ? 5'd1 : ((colors_q > 5'd16) ? 5'd16 : colors_q);
  end

  mep_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni,
    .x_min_i(x_min_q), .y_max_i(y_max_q), .x_step_i(x_step_q), .y_step_i(y_step_q),
    .pix_i,
    .q_ready_i(fq_ready), .q_valid_o(fq_valid), .q_data_o(fq_data)
  );

  mep_queue #(.WIDTH(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(fq_valid), .push_ready_o(fq_ready), .push_data_i(fq_data),
    .pop_valid_o(bq_valid), .pop_ready_i(bq_ready), .pop_data_o(bq_data)
  );

  mep_back #(.FRAC_BITS(FRAC_BITS), .ITER_BITS(ITER_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .q_valid_i(bq_valid), .q_ready_o(bq_ready), .q_data_i(bq_data),
    .res_o
  );

  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> 5'(res_o.color_index) < cfg.colors)
    else $error("color index not below palette size");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> 32'(res_o.iteration_index) < 32'(cfg.lim))
    else $error("iteration index not below iteration limit");

  a_queue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_valid && !fq_ready) |-> bq_valid)
    else $error("queue full while empty toward back stage");

endmodule

@@ verif/tb_mandelbrot_escape_time_pixel_core.sv @@
module tb_mandelbrot_escape_time_pixel_core;
  import mep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = FracBitsDef;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
  } pixel_t;

  typedef struct packed {
    logic [3:0]  color_index;
    logic [15:0] iteration_index;
  } escape_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  mep_pix_if #(.COORD_BITS(CoordBitsDef)) pix ();
  mep_res_if #(.ITER_BITS(IterBitsDef))   res ();

  mandelbrot_escape_time_pixel_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .res_o     (res)
  );

  // Shadow copy of the block's registers.
  longint      x_min_q;
  longint      y_max_q;
  longint      x_step_q;
  longint      y_step_q;
  int unsigned max_iter_q;
  int unsigned bailout_q;
  int unsigned colors_q;

  pixel_t  pixel_q[$];
  escape_t escape_q[$];
  int      sender_idle;
  int      recv_stall;
  bit      hold_pixels;
  int      err_count;
  int      results_seen;
  longint  cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint clamp_c(longint v);
    longint lim;
    lim = longint'(4) <<< FB;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic escape_t predict_escape(pixel_t p);
    longint      cr, ci, zr, zi, sr, si, cx, thr, mag;
    int unsigned lim, b, cc, i;
    escape_t     e;
    cr  = clamp_c(x_min_q + longint'(p.col) * x_step_q);
    ci  = clamp_c(y_max_q - longint'(p.row) * y_step_q);
    lim = (max_iter_q == 0) ? 1 : max_iter_q;
    b   = (bailout_q == 0) ? 1 : ((bailout_q > 2) ? 2 : bailout_q);
    cc  = (colors_q == 0) ? 1 : ((colors_q > 16) ? 16 : colors_q);
    thr = longint'(b * b) <<< FB;
    zr  = 0;
    zi  = 0;
    for (i = 0; i < lim; i++) begin
      sr  = fx_mul(zr, zr);
      si  = fx_mul(zi, zi);
      cx  = fx_mul(zr, zi);
      zr  = sr - si + cr;
      zi  = 2 * cx + ci;
      mag = fx_mul(zr, zr) + fx_mul(zi, zi);
      if (mag > thr || i + 1 == lim) break;
    end
    e.color_index     = 4'(i % cc);
    e.iteration_index = 16'(i);
    return e;
  endfunction

  // Driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix.valid <= 1'b0;
      pix.row   <= '0;
      pix.col   <= '0;
    end else if (!pix.valid || pix.ready) begin
      if (pixel_q.size() != 0 && !hold_pixels && $urandom_range(99) >= sender_idle) begin
        pixel_t p;
        p = pixel_q.pop_front();
        pix.valid <= 1'b1;
        pix.row   <= p.row;
        pix.col   <= p.col;
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        escape_q.push_back(predict_escape('{row: pix.row, col: pix.col}));
      end
      if (res.valid && res.ready) begin
        escape_t e;
        results_seen++;
        if (escape_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("Unexpected result word: color %0d iteration %0d",
                     res.color_index, res.iteration_index);
        end else begin
          e = escape_q.pop_front();
          if (e.color_index !== res.color_index ||
              e.iteration_index !== res.iteration_index) begin
            err_count++;
            if (err_count <= 10)
              $display("Mismatch: expected color %0d iteration %0d, got color %0d iteration %0d",
                       e.color_index, e.iteration_index,
                       res.color_index, res.iteration_index);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e r, logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= d;
    case (r)
      REG_X_MIN:    x_min_q = longint'($signed(d));
      REG_Y_MAX:    y_max_q = longint'($signed(d));
      REG_X_STEP:   x_step_q = longint'(d[30:0]);
      REG_Y_STEP:   y_step_q = longint'(d[30:0]);
      REG_MAX_ITER: max_iter_q = d[15:0];
      REG_BAILOUT:  bailout_q = d[1:0];
      REG_COLORS:   colors_q = d[4:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_q.size() != 0 || pix.valid || escape_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic add_pixel(int unsigned r, int unsigned c);
    pixel_q.push_back('{row: 12'(r), col: 12'(c)});
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle = 0;  recv_stall = 0;  end
      1: begin sender_idle = 67; recv_stall = 0;  end
      2: begin sender_idle = 0;  recv_stall = 67; end
      default: begin sender_idle = 23; recv_stall = 23; end
    endcase
  endtask

  initial begin
    clk_i       = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    res.ready   = 1'b0;
    pix.valid   = 1'b0;
    pix.row     = '0;
    pix.col     = '0;
    hold_pixels = 1'b0;
    err_count   = 0;
    results_seen = 0;
    cycles      = 0;
    x_min_q     = longint'(XMinRst);
    y_max_q     = longint'(YMaxRst);
    x_step_q    = longint'(XStepRst);
    y_step_q    = longint'(YStepRst);
    max_iter_q  = MaxIterRst;
    bailout_q   = BailoutRst;
    colors_q    = ColorsRst;
    set_idling(0);
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, corner pixels.
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(0, 4095);
    add_pixel(4095, 0);
    add_pixel(64, 128);
    add_pixel(100, 150);
    wait_idle();

    // Zero limit, zero bailout, zero palette size at the origin.
    write_reg(REG_X_MIN, 32'h0);
    write_reg(REG_Y_MAX, 32'h0);
    write_reg(REG_X_STEP, 32'h0);
    write_reg(REG_Y_STEP, 32'h0);
    write_reg(REG_MAX_ITER, 32'h0);
    write_reg(REG_BAILOUT, 32'h0);
    write_reg(REG_COLORS, 32'h0);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    wait_idle();

    // Oversized bailout and palette size, point inside the set.
    write_reg(REG_MAX_ITER, 32'd300);
    write_reg(REG_BAILOUT, 32'h3);
    write_reg(REG_COLORS, 32'h1F);
    add_pixel(0, 0);
    wait_idle();
    write_reg(REG_COLORS, 32'h11);
    wait_idle();
    add_pixel(7, 9);
    wait_idle();

    // Far points in several directions.
    write_reg(REG_X_MIN, 32'h7FFF_FFFF);
    write_reg(REG_Y_MAX, 32'h8000_0000);
    write_reg(REG_X_STEP, 32'hFFFF_FFFF);
    write_reg(REG_Y_STEP, 32'hFFFF_FFFF);
    write_reg(REG_MAX_ITER, 32'hFFFF);
    write_reg(REG_BAILOUT, 32'h1);
    write_reg(REG_COLORS, 32'd16);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(2048, 1);
    wait_idle();
    write_reg(REG_X_MIN, 32'h8000_0000);
    write_reg(REG_Y_MAX, 32'h7FFF_FFFF);
    add_pixel(0, 0);
    add_pixel(1, 2);
    wait_idle();

    // Full iteration limit at the origin and at the period-two point.
    write_reg(REG_X_MIN, 32'h0);
    write_reg(REG_Y_MAX, 32'h0);
    write_reg(REG_X_STEP, 32'h0);
    write_reg(REG_Y_STEP, 32'h0);
    write_reg(REG_BAILOUT, 32'h2);
    add_pixel(0, 0);
    wait_idle();
    write_reg(REG_MAX_ITER, 32'd5000);
    write_reg(REG_X_MIN, 32'hF000_0000);
    add_pixel(3, 3);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      set_idling(ph % 4);
      write_reg(REG_X_MIN, 32'(-$urandom_range(32'h2000_0000, 0) + $urandom_range(32'h0800_0000)));
      write_reg(REG_Y_MAX, $urandom_range(32'h1800_0000, 32'h0400_0000));
      write_reg(REG_X_STEP, $urandom_range(1 << 22, 1 << 18) | (32'($urandom_range(1)) << 31));
      write_reg(REG_Y_STEP, $urandom_range(1 << 22, 1 << 18));
      write_reg(REG_MAX_ITER, (ph == 11) ? 32'hFFFF_0001 : $urandom_range(200, 1));
      write_reg(REG_BAILOUT, $urandom_range(3));
      write_reg(REG_COLORS, $urandom_range(31));
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(9) == 0) add_pixel($urandom_range(4095), $urandom_range(4095));
        else add_pixel($urandom_range(255), $urandom_range(255));
      end
      if (ph == 5) begin
        repeat (20) @(posedge clk_i);
        hold_pixels = 1'b1;
        while (escape_q.size() != 0 || pix.valid) @(posedge clk_i);
        hold_pixels = 1'b0;
      end
      wait_idle();
    end

    while (escape_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    err_count += escape_q.size();
    $display("Checked %0d escape results over directed corners and twelve random windows,",
             results_seen);
    $display("with all register settings and all four handshake stall patterns.");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
